// ===== rtl/core/xxh_pkg.sv =====
// Package for the xxHash32 digest block: primes, widths, channel payloads and command type.
// No dependencies.
package xxh_pkg;
  localparam logic [31:0] XP1 = 32'h9E3779B1;
  localparam logic [31:0] XP2 = 32'h85EBCA77;
  localparam logic [31:0] XP3 = 32'hC2B2AE3D;
  localparam logic [31:0] XP4 = 32'h27D4EB2F;
  localparam logic [31:0] XP5 = 32'h165667B1;
  localparam int unsigned QueueDepth = 2;

  // Payload of one input beat
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_item;
  } xxh_in_t;

  // Payload of one digest beat
  typedef struct packed {
    logic [31:0] hash_value;
    logic [31:0] message_length;
  } xxh_out_t;

  // One command from the front to the back: a word and its framing.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;   // clamped to 0..4, meaningful on last
    logic        last;
  } xxh_cmd_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction
endpackage

// ===== rtl/core/xxh_if.sv =====
// Valid/ready channel interface carrying a payload of type T.
// No dependencies.
interface xxh_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/xxh_front.sv =====
// Front end: accepts items, clamps the byte count, and feeds a short command queue.
// Depends on xxh_pkg.
module xxh_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          data_word_i,
  input  logic [2:0]           byte_count_i,
  input  logic                 last_item_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output xxh_pkg::xxh_cmd_t    cmd_o,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i
);
  import xxh_pkg::*;

  xxh_cmd_t mem_q [QueueDepth];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;
  logic     push, pop;
  xxh_cmd_t cin;

  assign in_ready_o  = (cnt_q != 2'(QueueDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  // Classify: clamp counts above four
  always_comb begin
    cin.word = data_word_i;
    cin.last = last_item_i;
    cin.cnt  = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cin;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== rtl/core/xxh_back.sv =====
// Back end: sequencer around one shared 32x32 multiplier doing rounds, tail and avalanche.
// Depends on xxh_pkg.
module xxh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [31:0]       seed_i,
  input  xxh_pkg::xxh_cmd_t cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  output logic [31:0]       hash_value_o,
  output logic [31:0]       message_length_o,
  output logic              out_valid_o,
  input  logic              out_ready_i
);
  import xxh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RA   = 4'd1;  // acc += w*P2
  localparam logic [3:0] S_RB   = 4'd2;  // acc = rotl13(acc)*P1
  localparam logic [3:0] S_MRG  = 4'd3;  // start final
  localparam logic [3:0] S_PA   = 4'd4;  // h += pw*P3
  localparam logic [3:0] S_PB   = 4'd5;  // h = rotl17(h)*P4
  localparam logic [3:0] S_BA   = 4'd6;  // h += b*P5
  localparam logic [3:0] S_BB   = 4'd7;  // h = rotl11(h)*P1
  localparam logic [3:0] S_V1   = 4'd8;  // h = (h^h>>15)*P2
  localparam logic [3:0] S_V2   = 4'd9;  // h = (h^h>>13)*P3
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]  st_q;
  logic [31:0] lane_q [4];
  logic [31:0] pend_q [3];
  logic [1:0]  pcnt_q, idx_q;
  logic [1:0]  tidx_q;
  logic [2:0]  tail_q;
  logic        seen_q, fin_q;
  logic [31:0] len_q, h_q, w_q;
  logic        ov_q;
  logic [31:0] res_q, rlen_q;
  logic [31:0] ma, mb, mp;
  logic [31:0] lane_init [4];
  logic        load_out;

  assign mp = 32'(64'(ma) * 64'(mb));
  assign cmd_ready_o = (st_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign hash_value_o = res_q;
  assign message_length_o = rlen_q;
  assign load_out = (st_q == S_OUT) && (!ov_q || out_ready_i);

  assign lane_init[0] = seed_i + XP1 + XP2;
  assign lane_init[1] = seed_i + XP2;
  assign lane_init[2] = seed_i;
  assign lane_init[3] = seed_i - XP1;

  // Select multiplier operands per step
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_q)
      S_RA: begin ma = (idx_q == 2'd3) ? w_q : pend_q[idx_q]; mb = XP2; end
      S_RB: begin ma = rotl(lane_q[idx_q], 13); mb = XP1; end
      S_PA: begin ma = pend_q[tidx_q]; mb = XP3; end
      S_PB: begin ma = rotl(h_q, 17); mb = XP4; end
      S_BA: begin ma = 32'(w_q[8*tidx_q +: 8]); mb = XP5; end
      S_BB: begin ma = rotl(h_q, 11); mb = XP1; end
      S_V1: begin ma = h_q ^ (h_q >> 15); mb = XP2; end
      S_V2: begin ma = h_q ^ (h_q >> 13); mb = XP3; end
      default: ;
    endcase
  end

  // Sequence the work of one command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      pcnt_q <= 2'd0;
      seen_q <= 1'b0;
      len_q <= '0;
      ov_q <= 1'b0;
      idx_q <= 2'd0;
      tidx_q <= 2'd0;
      tail_q <= 3'd0;
      fin_q <= 1'b0;
    end else begin
      // Load a new digest beat, else drop the taken one
      if (load_out) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (cmd_valid_i) begin
          w_q <= cmd_i.word;
          fin_q <= cmd_i.last;
          if (!cmd_i.last || cmd_i.cnt == 3'd4) begin
            len_q <= len_q + (cmd_i.last ? 32'(cmd_i.cnt) : 32'd4);
            tail_q <= 3'd0;
            if (pcnt_q != 2'd3) begin
              pend_q[pcnt_q] <= cmd_i.word;
              pcnt_q <= pcnt_q + 2'd1;
              st_q <= cmd_i.last ? S_MRG : S_IDLE;
            end else begin
              if (!seen_q) begin
                for (int i = 0; i < 4; i++) lane_q[i] <= lane_init[i];
                seen_q <= 1'b1;
              end
              idx_q <= 2'd0;
              st_q <= S_RA;
            end
          end else begin
            len_q <= len_q + 32'(cmd_i.cnt);
            tail_q <= cmd_i.cnt;
            st_q <= S_MRG;
          end
        end
        S_RA: begin
          lane_q[idx_q] <= lane_q[idx_q] + mp;
          st_q <= S_RB;
        end
        S_RB: begin
          lane_q[idx_q] <= mp;
          idx_q <= idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            pcnt_q <= 2'd0;
            st_q <= fin_q ? S_MRG : S_IDLE;
          end else st_q <= S_RA;
        end
        S_MRG: begin
          h_q <= (seen_q ? rotl(lane_q[0], 1) + rotl(lane_q[1], 7) +
                           rotl(lane_q[2], 12) + rotl(lane_q[3], 18)
                         : seed_i + XP5) + len_q;
          tidx_q <= 2'd0;
          st_q <= (pcnt_q != 2'd0) ? S_PA : (tail_q != 3'd0) ? S_BA : S_V1;
        end
        S_PA: begin h_q <= h_q + mp; st_q <= S_PB; end
        S_PB: begin
          h_q <= mp;
          if (tidx_q + 2'd1 == pcnt_q) begin
            tidx_q <= 2'd0;
            st_q <= (tail_q != 3'd0) ? S_BA : S_V1;
          end else begin
            tidx_q <= tidx_q + 2'd1;
            st_q <= S_PA;
          end
        end
        S_BA: begin h_q <= h_q + mp; st_q <= S_BB; end
        S_BB: begin
          h_q <= mp;
          if (3'(tidx_q) + 3'd1 == tail_q) st_q <= S_V1;
          else begin tidx_q <= tidx_q + 2'd1; st_q <= S_BA; end
        end
        S_V1: begin h_q <= mp; st_q <= S_V2; end
        S_V2: begin h_q <= mp; st_q <= S_OUT; end
        S_OUT: if (load_out) begin
          res_q <= h_q ^ (h_q >> 16);
          rlen_q <= len_q;
          pcnt_q <= 2'd0;
          seen_q <= 1'b0;
          len_q <= '0;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/xxhash32_digest_top.sv =====
// Top level of the xxHash32 digest block: seed register, front queue and back sequencer.
// Depends on xxh_pkg, xxh_if, xxh_front and xxh_back.
// A non-last word that does not close a stripe is only buffered; a word closing a 16-byte
// stripe runs four lane rounds, two steps each on the one shared 32x32
// multiplier. The last item adds a merge step, a round per buffered tail word and per
// tail byte, the avalanche steps and an output step. A two-entry queue decouples input.
module xxhash32_digest_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  xxh_if.sink   in_ch,
  xxh_if.sink   cfg_ch,
  xxh_if.source out_ch
);
  import xxh_pkg::*;

  logic [31:0] seed_q;
  xxh_cmd_t    cmd;
  logic        cmd_valid, cmd_ready;

  // Hold the seed register
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= '0;
    else if (cfg_ch.valid) seed_q <= cfg_ch.data;
  end

  xxh_front u_front (
    .clk_i, .rst_ni,
    .data_word_i (in_ch.data.data_word),
    .byte_count_i(in_ch.data.byte_count),
    .last_item_i (in_ch.data.last_item),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  xxh_back u_back (
    .clk_i, .rst_ni,
    .seed_i          (seed_q),
    .cmd_i           (cmd),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .hash_value_o    (out_ch.data.hash_value),
    .message_length_o(out_ch.data.message_length),
    .out_valid_o     (out_ch.valid),
    .out_ready_i     (out_ch.ready)
  );
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for xxhash32_digest_top: random messages with a seed change per phase.
// Depends on xxh_pkg, xxh_if and the RTL of the xxHash32 digest block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xxh_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned SettleCycles  = 40;

  typedef enum int {IDLE_SEND, IDLE_RECV, IDLE_NONE} idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  xxh_if #(.T(xxh_in_t))     in_ch ();
  xxh_if #(.T(logic [31:0])) cfg_ch ();
  xxh_if #(.T(xxh_out_t))    out_ch ();

  xxhash32_digest_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  always #10 clk_i = ~clk_i;

  // Stimulus and expectations
  xxh_in_t    word_q[$];
  xxh_out_t   digest_q[$];
  idle_mode_e idle_mode = IDLE_SEND;
  bit         send_pause = 1'b0;
  bit         hold_go = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  // Shadow state of the hash engine
  logic [31:0] seed_sh;
  logic [31:0] lane_sh[4];
  logic [31:0] tail_words[3];
  int unsigned tail_cnt;
  logic [31:0] byte_total;
  bit          stripe_on;

  function automatic logic [31:0] rol(logic [31:0] x, int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] lane_mix(logic [31:0] acc, logic [31:0] w);
    logic [31:0] t;
    t = acc + w * XP2;
    return rol(t, 13) * XP1;
  endfunction

  // Buffer a full word or close a stripe with it
  task automatic absorb_word(logic [31:0] w);
    if (tail_cnt < 3) begin
      tail_words[tail_cnt] = w;
      tail_cnt++;
    end else begin
      if (!stripe_on) begin
        lane_sh[0] = seed_sh + XP1 + XP2;
        lane_sh[1] = seed_sh + XP2;
        lane_sh[2] = seed_sh;
        lane_sh[3] = seed_sh - XP1;
        stripe_on = 1'b1;
      end
      lane_sh[0] = lane_mix(lane_sh[0], tail_words[0]);
      lane_sh[1] = lane_mix(lane_sh[1], tail_words[1]);
      lane_sh[2] = lane_mix(lane_sh[2], tail_words[2]);
      lane_sh[3] = lane_mix(lane_sh[3], w);
      tail_cnt = 0;
    end
  endtask

  // Advance the shadow state by one accepted word; queue a digest on the last one
  task automatic predict_digest(xxh_in_t c);
    int unsigned nb;
    int unsigned rest;
    logic [31:0] h;
    xxh_out_t d;
    if (!c.last_item) begin
      byte_total += 32'd4;
      absorb_word(c.data_word);
    end else begin
      nb = (c.byte_count > 3'd4) ? 4 : c.byte_count;
      byte_total += nb;
      rest = nb;
      if (nb == 4) begin
        absorb_word(c.data_word);
        rest = 0;
      end
      if (stripe_on) h = rol(lane_sh[0], 1) + rol(lane_sh[1], 7) + rol(lane_sh[2], 12)
                         + rol(lane_sh[3], 18);
      else h = seed_sh + XP5;
      h += byte_total;
      for (int i = 0; i < tail_cnt; i++) begin
        h += tail_words[i] * XP3;
        h = rol(h, 17) * XP4;
      end
      for (int i = 0; i < rest; i++) begin
        h += {24'd0, c.data_word[8*i +: 8]} * XP5;
        h = rol(h, 11) * XP1;
      end
      h ^= h >> 15;
      h *= XP2;
      h ^= h >> 13;
      h *= XP3;
      h ^= h >> 16;
      d.hash_value = h;
      d.message_length = byte_total;
      digest_q.push_back(d);
      tail_cnt = 0;
      byte_total = '0;
      stripe_on = 1'b0;
    end
  endtask

  // Input driver: hold an offered beat until taken, else pick the next word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      bit take;
      bit go;
      take = in_ch.valid && in_ch.ready;
      if (take) begin
        predict_digest(in_ch.data);
        void'(word_q.pop_front());
      end
      if (in_ch.valid && !take) begin
        in_ch.valid <= 1'b1;
      end else begin
        go = (word_q.size() != 0) && !send_pause;
        if (idle_mode == IDLE_SEND && $urandom_range(99) < 27) go = 1'b0;
        if (idle_mode == IDLE_RECV && $urandom_range(99) < 60) go = 1'b0;
        in_ch.valid <= go;
        if (go) in_ch.data <= word_q[0];
      end
    end
  end

  // Output monitor: stall at random, compare each digest beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      xxh_out_t want;
      bit rdy;
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected digest %h len %0d",
                                      out_ch.data.hash_value, out_ch.data.message_length);
        end else begin
          want = digest_q.pop_front();
          if (out_ch.data.hash_value !== want.hash_value ||
              out_ch.data.message_length !== want.message_length) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("digest mismatch: hash exp %h got %h, len exp %0d got %0d",
                       want.hash_value, out_ch.data.hash_value,
                       want.message_length, out_ch.data.message_length);
          end
        end
      end
      rdy = 1'b1;
      if (idle_mode == IDLE_SEND && $urandom_range(99) < 60) rdy = 1'b0;
      if (idle_mode == IDLE_RECV && $urandom_range(99) < 27) rdy = 1'b0;
      if (hold_go && hold_cnt < HoldCycles) begin
        hold_cnt <= hold_cnt + 1;
        rdy = 1'b0;
      end
      out_ch.ready <= rdy;
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Queue one message of full words followed by a last word
  task automatic queue_msg(int unsigned n_words, logic [2:0] last_cnt, logic [31:0] w);
    xxh_in_t c;
    for (int i = 0; i < n_words; i++) begin
      c.data_word = rand_word();
      c.byte_count = 3'($urandom_range(7));
      c.last_item = 1'b0;
      word_q.push_back(c);
    end
    c.data_word = w;
    c.byte_count = last_cnt;
    c.last_item = 1'b1;
    word_q.push_back(c);
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || in_ch.valid || digest_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write the seed while the block is idle
  task automatic write_seed(logic [31:0] v);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    seed_sh = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned nw;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: nw = $urandom_range(60, 100);
        1, 2, 3, 4, 5: nw = $urandom_range(13, 40);
        default: nw = $urandom_range(0, 12);
      endcase
      queue_msg(nw, 3'($urandom_range(7)), rand_word());
      sent += nw + 1;
    end
  endtask

  initial begin
    seed_sh = '0;
    tail_cnt = 0;
    byte_total = '0;
    stripe_on = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty, each tail size, oversize counts, stripe edges, extreme words
    queue_msg(0, 3'd0, 32'hFFFF_FFFF);
    queue_msg(0, 3'd1, 32'hFFFF_FFFF);
    queue_msg(0, 3'd2, 32'h0000_0000);
    queue_msg(0, 3'd3, 32'hA5C3_5A3C);
    queue_msg(0, 3'd4, 32'hFFFF_FFFF);
    queue_msg(0, 3'd5, 32'h1234_5678);
    queue_msg(0, 3'd7, 32'hFFFF_FFFF);
    queue_msg(3, 3'd4, 32'h0000_0000);
    queue_msg(4, 3'd0, 32'hFFFF_FFFF);
    queue_msg(6, 3'd6, 32'h8000_0001);
    write_seed(32'hFFFF_FFFF);
    queue_msg(3, 3'd4, 32'hFFFF_FFFF);
    queue_msg(1, 3'd3, 32'h7FFF_FFFE);

    // Random phases, one idling pattern and one seed each
    write_seed($urandom);
    idle_mode = IDLE_SEND;
    random_phase(180);

    // Receiver holds off long while the sender keeps offering
    wait (word_q.size() < 60);
    hold_go = 1'b1;
    wait (hold_cnt >= HoldCycles);
    write_seed(32'h8000_0000);
    idle_mode = IDLE_RECV;
    random_phase(180);

    // Sender pauses until every digest has come back
    wait (word_q.size() < 40);
    send_pause = 1'b1;
    while (in_ch.valid || digest_q.size() != 0) @(posedge clk_i);
    send_pause = 1'b0;
    write_seed(32'h0000_0000);
    idle_mode = IDLE_NONE;
    random_phase(170);

    wait_drained();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
